// ===== rtl/bkcd_pkg.sv =====
// Package with the shared constants and types of the brightness-keyed colour delta table.
package bkcd_pkg;

  localparam int CHANNEL_MAX_DEF = 255;
  localparam int CH_W = 8;
  localparam int SUM_W = 10;
  localparam int DELTA_W = 9;
  localparam int WORD_W = 64;
  localparam int WIDX_W = 6;

  localparam logic [1:0] OP_TRAIN = 2'd0;
  localparam logic [1:0] OP_APPLY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [SUM_W-1:0] sum;
    logic [CH_W-1:0] s_r;
    logic [CH_W-1:0] s_g;
    logic [CH_W-1:0] s_b;
    logic [CH_W-1:0] t_r;
    logic [CH_W-1:0] t_g;
    logic [CH_W-1:0] t_b;
  } cmd_t;

endpackage

// ===== rtl/bkcd_front.sv =====
// Front end: takes items, drops unknown ops, sums r+g+b and queues commands for back end.
module bkcd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_operation,
  input  logic [7:0]           in_src_red,
  input  logic [7:0]           in_src_green,
  input  logic [7:0]           in_src_blue,
  input  logic [7:0]           in_tgt_red,
  input  logic [7:0]           in_tgt_green,
  input  logic [7:0]           in_tgt_blue,
  output logic                 cmd_valid,
  output bkcd_pkg::cmd_t       cmd,
  input  logic                 cmd_take
);
  import bkcd_pkg::*;

  cmd_t       q_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       push_ok, drop;
  cmd_t       c_in;

  always_comb begin
    c_in.op = in_operation;
    c_in.sum = SUM_W'(in_src_red) + SUM_W'(in_src_green) + SUM_W'(in_src_blue);
    c_in.s_r = in_src_red;
    c_in.s_g = in_src_green;
    c_in.s_b = in_src_blue;
    c_in.t_r = in_tgt_red;
    c_in.t_g = in_tgt_green;
    c_in.t_b = in_tgt_blue;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign drop      = (in_operation != OP_TRAIN) && (in_operation != OP_APPLY) &&
                     (in_operation != OP_CLEAR);
  assign push_ok   = in_push && !in_full && !drop;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= c_in;
    end
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push_ok) wp_r <= !wp_r;
      if (cmd_take) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, cmd_take};
    end
  end
endmodule

// ===== rtl/bkcd_back.sv =====
// Back end: valid-word scan, delta memory, saturation and result register.
module bkcd_back #(
  parameter int CHANNEL_MAX = bkcd_pkg::CHANNEL_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  bkcd_pkg::cmd_t cmd,
  output logic           cmd_take,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic           out_matched
);
  import bkcd_pkg::*;

  localparam int KEY_COUNT = 3 * CHANNEL_MAX + 1;
  localparam int KEY_WORDS = (KEY_COUNT + WORD_W - 1) / WORD_W;
  localparam int KW_W = $clog2(KEY_WORDS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  logic [WORD_W-1:0]      vld_r [KEY_WORDS];
  logic [3*DELTA_W-1:0]   mem [KEY_COUNT];
  logic [3*DELTA_W-1:0]   rd_r;
  logic [2:0]             st_r, st_nxt;
  cmd_t                   c_r;
  logic [KW_W-1:0]        w_r;
  logic [WIDX_W-1:0]      hit_bit;
  logic                   hit;
  logic [WORD_W-1:0]      masked;
  logic [SUM_W-1:0]       key_r;
  logic                   match_r;
  logic                   res_v_r, res_m_r;
  logic [7:0]             res_r_r, res_g_r, res_b_r;
  logic                   train_ok;

  function automatic logic [7:0] sat(input logic [CH_W-1:0] s,
                                     input logic [DELTA_W-1:0] d);
    logic signed [DELTA_W+1:0] v;
    v = $signed({2'b00, s}) + $signed({d[DELTA_W-1], d});
    if (v < 0) return 8'd0;
    else if (v > (DELTA_W+2)'(CHANNEL_MAX)) return 8'(CHANNEL_MAX);
    else return v[7:0];
  endfunction

  assign train_ok = (32'(cmd.sum) < KEY_COUNT);

  always_comb begin
    masked = vld_r[w_r[KW_W-1:0] < KW_W'(KEY_WORDS) ? w_r : '0];
    if (w_r == KW_W'(c_r.sum >> WIDX_W))
      masked = masked & ({WORD_W{1'b1}} << c_r.sum[WIDX_W-1:0]);
    hit = 1'b0;
    hit_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        hit = 1'b1;
        hit_bit = WIDX_W'(i);
      end
    end
  end

  assign cmd_take = (st_r == ST_IDLE) && cmd_valid;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (cmd_valid) begin
        if (cmd.op == OP_APPLY) st_nxt = ST_SCAN;
        else if (cmd.op == OP_CLEAR) st_nxt = ST_CLR;
      end
      ST_SCAN: begin
        if (32'(w_r) >= KEY_WORDS) st_nxt = ST_CALC;
        else if (hit) st_nxt = ST_READ;
      end
      ST_READ: st_nxt = ST_CALC;
      ST_CALC: if (!res_v_r) st_nxt = ST_IDLE;
      ST_CLR:  if (32'(w_r) == KEY_WORDS - 1) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.op == OP_TRAIN && train_ok) begin
      mem[cmd.sum] <= {DELTA_W'({1'b0, cmd.t_r}) - DELTA_W'({1'b0, cmd.s_r}),
                       DELTA_W'({1'b0, cmd.t_g}) - DELTA_W'({1'b0, cmd.s_g}),
                       DELTA_W'({1'b0, cmd.t_b}) - DELTA_W'({1'b0, cmd.s_b})};
    end
    if (st_r == ST_READ) rd_r <= mem[key_r];
    if (cmd_take) c_r <= cmd;
    if (st_r == ST_SCAN && hit && 32'(w_r) < KEY_WORDS)
      key_r <= SUM_W'({w_r, hit_bit});
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      res_v_r <= 1'b0;
      w_r     <= '0;
      for (int i = 0; i < KEY_WORDS; i++) vld_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_pop && res_v_r) res_v_r <= 1'b0;
      if (cmd_take) begin
        if (cmd.op == OP_APPLY)
          w_r <= train_ok ? KW_W'(cmd.sum >> WIDX_W) : KW_W'(KEY_WORDS);
        else
          w_r <= '0;
        if (cmd.op == OP_TRAIN && train_ok)
          vld_r[KW_W'(cmd.sum >> WIDX_W)][cmd.sum[WIDX_W-1:0]] <= 1'b1;
      end
      if (st_r == ST_SCAN) begin
        if (hit && 32'(w_r) < KEY_WORDS) begin
          match_r <= 1'b1;
        end else begin
          match_r <= 1'b0;
          if (32'(w_r) < KEY_WORDS) w_r <= w_r + 1'b1;
        end
      end
      if (st_r == ST_CLR) begin
        vld_r[w_r] <= '0;
        w_r <= w_r + 1'b1;
      end
      if (st_r == ST_CALC && !res_v_r) begin
        res_v_r <= 1'b1;
        res_m_r <= match_r;
        if (match_r) begin
          res_r_r <= sat(c_r.s_r, rd_r[3*DELTA_W-1:2*DELTA_W]);
          res_g_r <= sat(c_r.s_g, rd_r[2*DELTA_W-1:DELTA_W]);
          res_b_r <= sat(c_r.s_b, rd_r[DELTA_W-1:0]);
        end else begin
          res_r_r <= c_r.s_r;
          res_g_r <= c_r.s_g;
          res_b_r <= c_r.s_b;
        end
      end
    end
  end

  assign out_empty   = !res_v_r;
  assign out_red     = res_r_r;
  assign out_green   = res_g_r;
  assign out_blue    = res_b_r;
  assign out_matched = res_m_r;
endmodule

// ===== rtl/brightness_keyed_color_delta_lut.sv =====
// Brightness-keyed colour delta table, top level.
// Input channel: push/full with operation and source/target pixel fields.
// Train items store target minus source under the source sum r+g+b; apply items
// look up the smallest trained key at or above their sum, add its delta and
// saturate; clear items empty the valid map.
// Result channel: empty/pop; only apply items give a result.
// A two-entry command queue parts the front end from the back end.
// A train item is written at its take and does not hold the back end; a clear
// item is taken and then clears one valid word per cycle; an apply item scans
// one 64-bit valid word per cycle from the word holding its sum, then reads and adds.
// The back end takes a new item only from its idle state.
// Reset empties the valid map, the queue and the result register; the delta
// memory is not cleared and is read only for keys that were trained.
// When the receiver stalls, the result waits in its register, one more apply
// item is held in the back end and the queue fills, after which full rises.
module brightness_keyed_color_delta_lut #(
  parameter int CHANNEL_MAX = bkcd_pkg::CHANNEL_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_src_red,
  input  logic [7:0] in_src_green,
  input  logic [7:0] in_src_blue,
  input  logic [7:0] in_tgt_red,
  input  logic [7:0] in_tgt_green,
  input  logic [7:0] in_tgt_blue,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_matched
);
  import bkcd_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  bkcd_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_operation,
    .in_src_red, .in_src_green, .in_src_blue, .in_tgt_red, .in_tgt_green,
    .in_tgt_blue, .cmd_valid, .cmd, .cmd_take
  );

  bkcd_back #(.CHANNEL_MAX(CHANNEL_MAX)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .out_empty(empty),
    .out_pop(pop), .out_red, .out_green, .out_blue, .out_matched
  );
endmodule

// ===== rtl/bkcd_checker.sv =====
// Port-level checker for the colour delta table, with its bind statement.
module bkcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_red,
  input logic       out_matched
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("block not empty after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty && $stable(out_red) && $stable(out_matched))
    else $error("waiting result changed");
  a_no_fill_without_push: assert property (@(posedge clk) disable iff (!rst_n)
    (!full && !push) |=> !full)
    else $error("queue filled without an item");
  a_pop_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop) |=> empty)
    else $error("results back to back");
endmodule

bind brightness_keyed_color_delta_lut bkcd_checker u_chk (
  .clk, .rst_n, .push, .full, .empty, .pop, .out_red, .out_matched
);
